FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication
`define ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/cpdc_pkg.sv
// types, constants and the crc-32 byte update for the packet deframer
package cpdc_pkg;

    localparam int unsigned CFG_W          = 11;
    localparam logic [CFG_W-1:0] MAX_PAYLOAD_RESET = 11'd1024;

    localparam logic [31:0] CRC_POLY       = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT       = 32'hFFFF_FFFF;
    localparam logic [7:0]  MAGIC_BYTE     = 8'h4D;
    localparam int unsigned MAGIC_LEN      = 2;
    localparam int unsigned HEADER_LEN     = 5;
    localparam int unsigned DELAY_DEPTH    = 4;
    localparam int unsigned FRAME_OVERHEAD = 11;
    localparam int unsigned QUEUE_DEPTH    = 3;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef logic [7:0] byte_t;

    typedef enum logic [2:0] {
        VERDICT_OK        = 3'd0,
        VERDICT_TOO_SHORT = 3'd1,
        VERDICT_BAD_MAGIC = 3'd2,
        VERDICT_BAD_CRC   = 3'd3,
        VERDICT_TOO_LONG  = 3'd4
    } verdict_t;

    typedef struct packed {
        byte_t rx_byte;
        logic  end_of_transfer;
    } in_word_t;

    typedef struct packed {
        logic        kind;
        byte_t       payload_byte;
        verdict_t    verdict;
        byte_t       field_a;
        byte_t       field_b;
        byte_t       field_c;
        logic [15:0] declared_length;
        logic        frame_end;
    } out_word_t;

    // results made by one accepted word, in delivery order
    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } push_t;

    // reflected crc-32, one byte, unrolled over its eight bits
    function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input byte_t b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

FILE: rtl/crc32_packet_deframer_checker.sv
// top level of the crc-32 framed packet deframer and checker
//
// Takes one transfer as a byte stream, one word per cycle while s_ready is high, with
// end_of_transfer on the final byte. Expected frame: 0x4D 0x4D, three header bytes (type,
// channel, sequence), a big-endian 16-bit length, the payload, then a big-endian reflected
// CRC-32 over all bytes before it. The last four bytes are held in a delay line; bytes
// leaving it at frame position 7 or later come out straight away as tentative payload
// words (kind 0), so the consumer must drop them if the verdict is not ok. The final byte
// gives a verdict word (kind 1, frame_end 1): ok with the header fields and declared
// length, or too long, too short, bad magic, bad crc in that priority. The declared length
// is reported, not checked. Once a transfer passes max_payload (clamped to
// MAX_PAYLOAD_LIMIT) plus 11 bytes, further bytes are ignored and the verdict is too long.
// Rate: one byte per cycle while s_ready is high; the byte update of the CRC and the
// checks sit between the frame state registers and a three-entry result queue. The final
// byte of a transfer that releases a payload byte makes two result words, which enter the
// queue together, so s_ready drops for one cycle after it when m_ready stays high. s_ready
// comes from the queue fill only, with no path from m_ready. max_payload is written
// through cfg_wr_en / cfg_wr_data whilst the block is idle, which only the user enforces.
`include "assert_macros.svh"

module crc32_packet_deframer_checker #(
    parameter int unsigned MAX_PAYLOAD_LIMIT = 1024
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [cpdc_pkg::CFG_W-1:0]         cfg_wr_data,
    // byte stream in
    input  logic                               s_valid,
    output logic                               s_ready,
    input  cpdc_pkg::in_word_t                 s_data,
    // result words out
    output logic                               m_valid,
    input  logic                               m_ready,
    output cpdc_pkg::out_word_t                m_data
);
    import cpdc_pkg::*;

    // largest effective maximum the 11-bit register can ask for
    localparam int unsigned CFG_MAX = (1 << CFG_W) - 1;
    localparam int unsigned EFF_MAX = (MAX_PAYLOAD_LIMIT > CFG_MAX) ? CFG_MAX
                                                                    : MAX_PAYLOAD_LIMIT;
    localparam logic [CFG_W-1:0] LIMIT_CLAMP = CFG_W'(EFF_MAX);
    // the byte count stops at eff + overhead
    localparam int unsigned CNT_W = $clog2(EFF_MAX + FRAME_OVERHEAD + 1);

    // configuration register
    logic [CFG_W-1:0] max_payload_reg;
    logic [CFG_W-1:0] eff_max;
    logic [CNT_W-1:0] count_limit;

    // frame state
    logic [CNT_W-1:0] byte_count_reg,  byte_count_next;
    logic [31:0]      crc_reg,         crc_next;
    byte_t            delay_reg  [DELAY_DEPTH];
    byte_t            delay_next [DELAY_DEPTH];
    byte_t            header_reg  [HEADER_LEN];
    byte_t            header_next [HEADER_LEN];
    logic             magic_ok_reg,    magic_ok_next;
    logic             overflow_reg,    overflow_next;

    logic             accept;
    logic             overflow_now;
    logic [31:0]      trailer;
    verdict_t         verdict;
    out_word_t        payload_word;
    out_word_t        verdict_word;
    push_t            push;

    assign eff_max     = (max_payload_reg > LIMIT_CLAMP) ? LIMIT_CLAMP : max_payload_reg;
    assign count_limit = CNT_W'(eff_max) + CNT_W'(FRAME_OVERHEAD);

    assign accept       = s_valid && s_ready;
    // a byte that would take the count past the limit latches overflow
    assign overflow_now = overflow_reg || (byte_count_reg >= count_limit);

    always_comb begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        magic_ok_next   = magic_ok_reg;
        overflow_next   = overflow_reg;
        for (int i = 0; i < DELAY_DEPTH; i++) begin
            delay_next[i] = delay_reg[i];
        end
        for (int i = 0; i < HEADER_LEN; i++) begin
            header_next[i] = header_reg[i];
        end
        payload_word = '0;
        verdict_word = '0;
        verdict      = VERDICT_OK;
        trailer      = '0;
        push         = '0;

        if (accept) begin
            overflow_next = overflow_now;
            if (!overflow_now) begin
                // magic bytes
                if (byte_count_reg < CNT_W'(MAGIC_LEN) && s_data.rx_byte != MAGIC_BYTE) begin
                    magic_ok_next = 1'b0;
                end
                // header capture
                for (int i = 0; i < HEADER_LEN; i++) begin
                    if (byte_count_reg == CNT_W'(i + MAGIC_LEN)) begin
                        header_next[i] = s_data.rx_byte;
                    end
                end
                // byte leaving the delay line feeds the crc, payload once past the header
                if (byte_count_reg >= CNT_W'(DELAY_DEPTH)) begin
                    crc_next = crc32_byte(crc_reg, delay_reg[0]);
                    if (byte_count_reg >= CNT_W'(FRAME_OVERHEAD)) begin
                        payload_word.kind         = KIND_PAYLOAD;
                        payload_word.payload_byte = delay_reg[0];
                        push.count                = 2'd1;
                        push.first                = payload_word;
                    end
                end
                for (int i = 0; i < DELAY_DEPTH - 1; i++) begin
                    delay_next[i] = delay_reg[i + 1];
                end
                delay_next[DELAY_DEPTH - 1] = s_data.rx_byte;
                byte_count_next = byte_count_reg + CNT_W'(1);
            end

            if (s_data.end_of_transfer) begin
                trailer = {delay_next[0], delay_next[1], delay_next[2], delay_next[3]};
                priority if (overflow_next) begin
                    verdict = VERDICT_TOO_LONG;
                end else if (byte_count_next < CNT_W'(FRAME_OVERHEAD)) begin
                    verdict = VERDICT_TOO_SHORT;
                end else if (!magic_ok_next) begin
                    verdict = VERDICT_BAD_MAGIC;
                end else if (trailer != ~crc_next) begin
                    verdict = VERDICT_BAD_CRC;
                end else begin
                    verdict = VERDICT_OK;
                end

                verdict_word.kind      = KIND_VERDICT;
                verdict_word.verdict   = verdict;
                verdict_word.frame_end = 1'b1;
                if (verdict == VERDICT_OK) begin
                    verdict_word.field_a         = header_reg[0];
                    verdict_word.field_b         = header_reg[1];
                    verdict_word.field_c         = header_reg[2];
                    verdict_word.declared_length = {header_reg[3], header_reg[4]};
                end

                if (push.count == 2'd0) begin
                    push.first = verdict_word;
                end else begin
                    push.second = verdict_word;
                end
                push.count = push.count + 2'd1;

                // back to the start-of-frame state
                byte_count_next = '0;
                crc_next        = CRC_INIT;
                magic_ok_next   = 1'b1;
                overflow_next   = 1'b0;
                for (int i = 0; i < DELAY_DEPTH; i++) begin
                    delay_next[i] = '0;
                end
                for (int i = 0; i < HEADER_LEN; i++) begin
                    header_next[i] = '0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_payload_reg <= MAX_PAYLOAD_RESET;
        end else if (cfg_wr_en) begin
            max_payload_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_count_reg <= '0;
            crc_reg        <= CRC_INIT;
            magic_ok_reg   <= 1'b1;
            overflow_reg   <= 1'b0;
            for (int i = 0; i < DELAY_DEPTH; i++) begin
                delay_reg[i] <= '0;
            end
            for (int i = 0; i < HEADER_LEN; i++) begin
                header_reg[i] <= '0;
            end
        end else begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            magic_ok_reg   <= magic_ok_next;
            overflow_reg   <= overflow_next;
            for (int i = 0; i < DELAY_DEPTH; i++) begin
                delay_reg[i] <= delay_next[i];
            end
            for (int i = 0; i < HEADER_LEN; i++) begin
                header_reg[i] <= header_next[i];
            end
        end
    end

    // result queue decouples the two sides
    cpdc_result_queue u_result_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .has_room (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // the end of a transfer always leaves a clean frame state
    `ASSERT_NXT(a_clear_after_end, aclk, aresetn, accept && s_data.end_of_transfer, byte_count_reg == '0 && !overflow_reg && magic_ok_reg)
    // stalling the input only ever happens with results waiting
    `ASSERT_IMP(a_stall_has_results, aclk, aresetn, !s_ready, m_valid)
    // payload words never carry the end-of-frame mark
    `ASSERT_IMP(a_payload_not_end, aclk, aresetn, m_valid && m_data.kind == KIND_PAYLOAD, !m_data.frame_end)

endmodule

FILE: rtl/cpdc_result_queue.sv
// three-entry shift queue between the deframer logic and the result port
module cpdc_result_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  cpdc_pkg::push_t     push,
    output logic                has_room,
    output logic                m_valid,
    input  logic                m_ready,
    output cpdc_pkg::out_word_t m_data
);
    import cpdc_pkg::*;

    out_word_t  slot_reg  [QUEUE_DEPTH];
    out_word_t  slot_next [QUEUE_DEPTH];
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic [1:0] count_pop;
    logic       pop;

    // room for two results regardless of the far side
    assign has_room = (count_reg <= 2'd1);
    assign m_valid  = (count_reg != 2'd0);
    assign m_data   = slot_reg[0];
    assign pop      = m_valid && m_ready;
    assign count_pop = count_reg - {1'b0, pop};

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_next[i] = slot_reg[i];
            if (2'(i) < count_pop) begin
                if (pop && (i + 1 < QUEUE_DEPTH)) begin
                    slot_next[i] = slot_reg[i + 1];
                end
            end else if (2'(i) == count_pop && push.count != 2'd0) begin
                slot_next[i] = push.first;
            end else if (3'(i) == ({1'b0, count_pop} + 3'd1) && push.count == 2'd2) begin
                slot_next[i] = push.second;
            end
        end
        count_next = count_pop + push.count;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= 2'd0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            slot_reg[i] <= slot_next[i];
        end
    end

endmodule

FILE: sim/frame_verdict_checker.sv
// checker: predicts the deframer's result words and compares them as they leave
`timescale 1ns / 100ps

module frame_verdict_checker #(
    parameter int unsigned PAYLOAD_LIMIT = 1024
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       cfg_wr_en,
    input  logic [cpdc_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                       s_valid,
    input  logic                       s_ready,
    input  cpdc_pkg::in_word_t         s_data,
    input  logic                       m_valid,
    input  logic                       m_ready,
    input  cpdc_pkg::out_word_t        m_data,
    output int unsigned                fail_count,
    output int unsigned                pending_count
);
    import cpdc_pkg::*;

    logic [CFG_W-1:0] max_payload;
    int unsigned      frame_len;
    logic [31:0]      crc_run;
    byte_t            delay_line [DELAY_DEPTH];
    byte_t            header [HEADER_LEN];
    logic             magic_good;
    logic             overflowed;
    out_word_t        expected_words [$];

    // reflected crc-32, one input bit per step
    function automatic logic [31:0] crc_next(input logic [31:0] crc, input byte_t b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    task automatic clear_frame();
        frame_len  = 0;
        crc_run    = CRC_INIT;
        magic_good = 1'b1;
        overflowed = 1'b0;
        foreach (delay_line[i]) delay_line[i] = '0;
        foreach (header[i]) header[i] = '0;
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: %s mismatch, got 0x%0h expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    task automatic predict_word(input in_word_t w);
        int unsigned limit;
        out_word_t   res;
        byte_t       leaving;
        logic [31:0] trailer;
        verdict_t    v;
        limit = (int'(max_payload) > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : int'(max_payload);
        if (!overflowed && frame_len + 1 > limit + FRAME_OVERHEAD) overflowed = 1'b1;
        if (!overflowed) begin
            if (frame_len < MAGIC_LEN && w.rx_byte != MAGIC_BYTE) magic_good = 1'b0;
            if (frame_len >= MAGIC_LEN && frame_len < MAGIC_LEN + HEADER_LEN)
                header[frame_len - MAGIC_LEN] = w.rx_byte;
            if (frame_len >= DELAY_DEPTH) begin
                leaving = delay_line[0];
                crc_run = crc_next(crc_run, leaving);
                // past the header: tentative payload word
                if (frame_len - DELAY_DEPTH >= MAGIC_LEN + HEADER_LEN) begin
                    res              = '0;
                    res.kind         = KIND_PAYLOAD;
                    res.payload_byte = leaving;
                    res.verdict      = VERDICT_OK;
                    expected_words.push_back(res);
                end
            end
            for (int i = 0; i < DELAY_DEPTH - 1; i++) delay_line[i] = delay_line[i + 1];
            delay_line[DELAY_DEPTH - 1] = w.rx_byte;
            frame_len++;
        end
        if (w.end_of_transfer) begin
            trailer = {delay_line[0], delay_line[1], delay_line[2], delay_line[3]};
            if (overflowed) v = VERDICT_TOO_LONG;
            else if (frame_len < FRAME_OVERHEAD) v = VERDICT_TOO_SHORT;
            else if (!magic_good) v = VERDICT_BAD_MAGIC;
            else if (trailer != ~crc_run) v = VERDICT_BAD_CRC;
            else v = VERDICT_OK;
            res           = '0;
            res.kind      = KIND_VERDICT;
            res.verdict   = v;
            res.frame_end = 1'b1;
            if (v == VERDICT_OK) begin
                res.field_a         = header[0];
                res.field_b         = header[1];
                res.field_c         = header[2];
                res.declared_length = {header[3], header[4]};
            end
            expected_words.push_back(res);
            clear_frame();
        end
    endtask

    task automatic compare_word(input out_word_t got);
        out_word_t want;
        if (expected_words.size() == 0) begin
            report_mismatch("unexpected result word", 64'(got), 64'd0);
        end else begin
            want = expected_words.pop_front();
            if (got.kind !== want.kind)
                report_mismatch("kind", 64'(got.kind), 64'(want.kind));
            if (got.payload_byte !== want.payload_byte)
                report_mismatch("payload_byte", 64'(got.payload_byte), 64'(want.payload_byte));
            if (got.verdict !== want.verdict)
                report_mismatch("verdict", 64'(got.verdict), 64'(want.verdict));
            if (got.field_a !== want.field_a)
                report_mismatch("field_a", 64'(got.field_a), 64'(want.field_a));
            if (got.field_b !== want.field_b)
                report_mismatch("field_b", 64'(got.field_b), 64'(want.field_b));
            if (got.field_c !== want.field_c)
                report_mismatch("field_c", 64'(got.field_c), 64'(want.field_c));
            if (got.declared_length !== want.declared_length)
                report_mismatch("declared_length", 64'(got.declared_length),
                                64'(want.declared_length));
            if (got.frame_end !== want.frame_end)
                report_mismatch("frame_end", 64'(got.frame_end), 64'(want.frame_end));
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            max_payload = MAX_PAYLOAD_RESET;
            clear_frame();
            expected_words.delete();
            fail_count = 0;
        end else begin
            if (cfg_wr_en) max_payload = cfg_wr_data;
            if (s_valid && s_ready) predict_word(s_data);
            if (m_valid && m_ready) compare_word(m_data);
        end
        pending_count <= expected_words.size();
    end

endmodule

FILE: sim/testbench.sv
// testbench top: frame stimulus, handshake pacing and the final verdict for the deframer
`timescale 1ns / 100ps

module testbench;
    import cpdc_pkg::*;

    localparam int unsigned PAYLOAD_LIMIT   = 1024;
    localparam int unsigned HOLD_OFF_CYCLES = 200;  // receiver blackout in the pressure phase
    localparam int unsigned STEADY_CYCLES   = 600;  // receiver does not stall for this stretch after the blackout
    localparam int unsigned PHASE_BYTES     = 140;  // random bytes per register setting
    localparam int unsigned N_PHASES        = 8;
    localparam int unsigned HOLD_OFF_PHASE  = 2;    // phase run with the receiver blacked out

    typedef enum logic [1:0] {
        FLAW_NONE,
        FLAW_BAD_CRC,
        FLAW_BAD_MAGIC
    } frame_flaw_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [CFG_W-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    in_word_t         s_data;
    logic             m_valid;
    logic             m_ready;
    out_word_t        m_data;
    int unsigned      fail_count;
    int unsigned      pending_count;

    byte_t            frame_q [$];        // bytes of the transfer about to go out
    bit               steady_send;        // sender offers words back to back
    bit               hold_off_req;       // receiver should start its long blackout

    crc32_packet_deframer_checker #(
        .MAX_PAYLOAD_LIMIT(PAYLOAD_LIMIT)
    ) u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    frame_verdict_checker #(
        .PAYLOAD_LIMIT(PAYLOAD_LIMIT)
    ) u_checker (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_data        (s_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_data        (m_data),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // hard stop: a run that hangs is reported as failed
    initial begin
        #2_000_000;
        $display("** crc32_packet_deframer_checker: FAILED **");
        $finish;
    end

    // trailer generator for the frames we build, bitwise reflected crc-32
    function automatic logic [31:0] frame_crc(input logic [31:0] crc, input byte_t b);
        logic [31:0] c;
        logic        fb;
        c = crc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) c = c ^ CRC_POLY;
        end
        return c;
    endfunction

    // offer one word and hold it until the deframer takes it
    task automatic send_word(input byte_t b, input logic last);
        // random gaps, about 9 in a hundred, none in the pressure phase
        while (!steady_send && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= '{rx_byte: b, end_of_transfer: last};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic send_transfer();
        foreach (frame_q[i]) send_word(frame_q[i], (i == frame_q.size() - 1));
    endtask

    // magic, header, declared length, payload, big-endian trailer; flaws go in on request
    task automatic make_frame(input int unsigned payload_len, input frame_flaw_t flaw,
                              input byte_t f_a, input byte_t f_b, input byte_t f_c,
                              input logic [15:0] declared);
        logic [31:0] crc;
        int unsigned spot;
        frame_q.delete();
        frame_q.push_back(MAGIC_BYTE);
        frame_q.push_back(MAGIC_BYTE);
        frame_q.push_back(f_a);
        frame_q.push_back(f_b);
        frame_q.push_back(f_c);
        frame_q.push_back(declared[15:8]);
        frame_q.push_back(declared[7:0]);
        repeat (payload_len) frame_q.push_back(byte_t'($urandom));
        // a wrong magic byte with a trailer that still matches
        if (flaw == FLAW_BAD_MAGIC) begin
            spot = $urandom_range(1);
            frame_q[spot] = frame_q[spot] ^ byte_t'($urandom_range(1, 255));
        end
        crc = CRC_INIT;
        foreach (frame_q[i]) crc = frame_crc(crc, frame_q[i]);
        crc = ~crc;
        frame_q.push_back(crc[31:24]);
        frame_q.push_back(crc[23:16]);
        frame_q.push_back(crc[15:8]);
        frame_q.push_back(crc[7:0]);
        // single flipped bit past the magic: always caught by the crc
        if (flaw == FLAW_BAD_CRC) begin
            spot = $urandom_range(MAGIC_LEN, frame_q.size() - 1);
            frame_q[spot] = frame_q[spot] ^ byte_t'(8'h01 << $urandom_range(7));
        end
    endtask

    // stop offering and wait for every expected word, then let the pipe settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_max_payload(input logic [CFG_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // receiver: random stalls, one long blackout in the pressure phase so the result
    // queue fills and s_ready drops, then a stretch with no stalls at all
    initial begin
        int unsigned steady_left;
        bit          held_off;
        steady_left = 0;
        held_off    = 1'b0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_off_req && !held_off) begin
                held_off = 1'b1;
                m_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge aclk);
                steady_left = STEADY_CYCLES;
            end
            if (steady_left != 0) begin
                steady_left--;
                m_ready <= 1'b1;
            end else begin
                m_ready <= ($urandom_range(99) >= 9);
            end
        end
    end

    initial begin
        logic [CFG_W-1:0] phase_cfg [N_PHASES];
        int unsigned      limit;
        int unsigned      cap;
        int unsigned      sent;
        int unsigned      pick;
        int unsigned      n;
        frame_flaw_t      flaw;

        s_valid     <= 1'b0;
        s_data      <= '0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        aresetn     <= 1'b0;
        steady_send  = 1'b0;
        hold_off_req = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part with the smallest maximum: frames with at most one payload byte
        write_max_payload('0);
        // lone zero byte: too short
        frame_q.delete();
        frame_q.push_back(8'h00);
        send_transfer();
        // empty frame at exactly the limit, header fields at their extremes
        make_frame(0, FLAW_NONE, 8'hFF, 8'h00, 8'hFF, 16'hFFFF);
        send_transfer();
        // one payload byte over a zero maximum: too long wins over everything
        make_frame(1, FLAW_NONE, 8'h00, 8'hFF, 8'h00, 16'h0000);
        send_transfer();

        // register settings: clamped top value, tiny ones, the exact limit, one below it, 16 and a random one
        phase_cfg = '{11'd2047, 11'd3, 11'd1024, 11'd0, CFG_W'($urandom_range(4, 60)),
                      11'd1023, 11'd1, 11'd16};

        for (int p = 0; p < N_PHASES; p++) begin
            wait_idle();
            write_max_payload(phase_cfg[p]);
            limit = (int'(phase_cfg[p]) > PAYLOAD_LIMIT) ? PAYLOAD_LIMIT : int'(phase_cfg[p]);
            cap   = (limit < 24) ? limit : 24;

            // pressure phase: the sender streams with no gaps while the receiver blacks out
            if (p == HOLD_OFF_PHASE) begin
                steady_send  = 1'b1;
                hold_off_req = 1'b1;
            end

            sent = 0;
            while (sent < PHASE_BYTES) begin
                pick = $urandom_range(99);
                if (pick < 75) begin
                    // well-formed frames with random content, some flawed, some too long
                    n    = $urandom_range(0, cap);
                    flaw = FLAW_NONE;
                    if (pick < 8) flaw = FLAW_BAD_CRC;
                    else if (pick < 14) flaw = FLAW_BAD_MAGIC;
                    else if (pick < 17 && limit <= 60) n = limit;
                    else if (pick < 30 && limit <= 60) n = limit + $urandom_range(1, 3);
                    make_frame(n, flaw, byte_t'($urandom), byte_t'($urandom),
                               byte_t'($urandom),
                               ($urandom_range(3) == 0) ? 16'($urandom) : 16'(n));
                    // now and then a frame cut short at the end
                    if (pick >= 70) repeat ($urandom_range(1, 4)) void'(frame_q.pop_back());
                end else begin
                    // noise, sometimes starting like a real frame
                    frame_q.delete();
                    n = $urandom_range(1, 16);
                    for (int i = 0; i < n; i++)
                        frame_q.push_back((i < 2 && $urandom_range(1) == 1) ?
                                          MAGIC_BYTE : byte_t'($urandom));
                end
                sent += frame_q.size();
                send_transfer();
            end

            steady_send  = 1'b0;
            hold_off_req = 1'b0;
        end

        wait_idle();
        if (fail_count == 0 && pending_count == 0) begin
            $display("** crc32_packet_deframer_checker: PASSED **");
        end else begin
            $display("** crc32_packet_deframer_checker: FAILED **");
        end
        $finish;
    end

endmodule
